// File: rtl/core/typed_complex_arithmetic_top_defines.svh
// Assertion macros for the typed complex arithmetic block.
`ifndef TYPED_COMPLEX_ARITHMETIC_TOP_DEFINES_SVH
`define TYPED_COMPLEX_ARITHMETIC_TOP_DEFINES_SVH

// Check a property at every rising edge outside reset.
`define TCA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every rising edge, reset included.
`define TCA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/tca_pkg.sv
// Shared types and codes of the typed complex arithmetic block.
package tca_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  localparam logic [1:0] TY_INT  = 2'd0;
  localparam logic [1:0] TY_REAL = 2'd1;
  localparam logic [1:0] TY_CPLX = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef struct packed {
    op_t        op;
    logic [1:0] rtype;
  } ctl_t;

  typedef struct packed {
    ctl_t ctl;
    logic dz;
    logic neg_re;
    logic neg_im;
  } dctl_t;

endpackage

// File: rtl/core/tca_if.sv
// Request and response channel interfaces.
interface tca_req_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [1:0]          left_type;
  logic signed [W-1:0] left_re;
  logic signed [W-1:0] left_im;
  logic [1:0]          right_type;
  logic signed [W-1:0] right_re;
  logic signed [W-1:0] right_im;

  modport source (output valid, kind, left_type, left_re, left_im, right_type, right_re,
                  right_im, input ready);
  modport sink (input valid, kind, left_type, left_re, left_im, right_type, right_re,
                right_im, output ready);
endinterface

interface tca_rsp_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic [1:0]          result_type;
  logic signed [W-1:0] result_re;
  logic signed [W-1:0] result_im;
  logic [1:0]          status;

  modport source (output valid, result_type, result_re, result_im, status, input ready);
  modport sink (input valid, result_type, result_re, result_im, status, output ready);
endinterface

// File: rtl/core/typed_complex_arithmetic_top.sv
// Throughput: one transaction per cycle unless the response stalls the pipeline.
// The divider yields one quotient bit per stage.
// Every item runs the full pipeline, so the divider depth sets the latency.
// A stalled response holds the whole pipeline; nothing is dropped or repeated.
// Reset is synchronous and clears only the valid bits; the pipeline is empty after it.
module typed_complex_arithmetic_top #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  tca_req_if.sink   req,
  tca_rsp_if.source rsp
);
  import tca_pkg::*;
  `include "typed_complex_arithmetic_top_defines.svh"

  localparam int NB = 2 * WORD_BITS + 1 + FRAC_BITS;

  logic                  adv;
  logic                  f_valid, d_valid, b_valid;
  dctl_t                 f_ctl, d_ctl;
  logic [NB-1:0]         f_re, f_im, d_re, d_im;
  logic [2*WORD_BITS-1:0] f_den;
  logic [1:0]            b_type, b_status;
  logic signed [WORD_BITS-1:0] b_re, b_im;

  assign adv = !b_valid || rsp.ready;
  assign req.ready = adv;

  tca_front #(.W(WORD_BITS), .F(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .en(adv), .in_valid(req.valid),
    .kind(req.kind), .left_type(req.left_type), .left_re(req.left_re),
    .left_im(req.left_im), .right_type(req.right_type), .right_re(req.right_re),
    .right_im(req.right_im), .out_valid(f_valid), .out_ctl(f_ctl),
    .num_re(f_re), .num_im(f_im), .den(f_den)
  );

  tca_divider #(.W(WORD_BITS), .F(FRAC_BITS)) u_divider (
    .clk(clk), .rst(rst), .en(adv), .in_valid(f_valid), .in_ctl(f_ctl),
    .in_re(f_re), .in_im(f_im), .in_den(f_den),
    .out_valid(d_valid), .out_ctl(d_ctl), .out_re(d_re), .out_im(d_im)
  );

  tca_back #(.W(WORD_BITS), .F(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .en(adv), .in_valid(d_valid), .in_ctl(d_ctl),
    .in_re(d_re), .in_im(d_im), .out_valid(b_valid), .result_type(b_type),
    .result_re(b_re), .result_im(b_im), .status(b_status)
  );

  assign rsp.valid       = b_valid;
  assign rsp.result_type = b_type;
  assign rsp.result_re   = b_re;
  assign rsp.result_im   = b_im;
  assign rsp.status      = b_status;

  `TCA_ASSERT(a_dz_zero, b_valid && b_status == ST_DZ |-> b_re == '0 && b_im == '0, "divide by zero result not cleared")
  `TCA_ASSERT(a_im_zero, b_valid && b_type != TY_CPLX |-> b_im == '0, "imaginary part set on non-complex result")
  `TCA_ASSERT(a_dz_type, b_valid && b_status == ST_DZ |-> b_type != TY_INT, "divide by zero on integer result")
  `TCA_ASSERT_ALWAYS(a_rst_empty, rst |=> !b_valid, "response valid after reset")

endmodule

// File: rtl/core/tca_front.sv
// Operand decode, products, sums and divider setup: four pipeline stages.
module tca_front #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [1:0]                       kind,
  input  logic [1:0]                       left_type,
  input  logic signed [W-1:0]              left_re,
  input  logic signed [W-1:0]              left_im,
  input  logic [1:0]                       right_type,
  input  logic signed [W-1:0]              right_re,
  input  logic signed [W-1:0]              right_im,
  output logic                             out_valid,
  output tca_pkg::dctl_t                   out_ctl,
  output logic [2*W+F:0]                   num_re,
  output logic [2*W+F:0]                   num_im,
  output logic [2*W-1:0]                   den
);
  import tca_pkg::*;

  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int NB = SW + F;
  localparam logic [W-1:0] ONE_W = W'(1);
  localparam logic [W-1:0] FMASK = (ONE_W << F) - ONE_W;

  logic                 v1, v2, v3;
  ctl_t                 ctl1, ctl2, ctl3;
  ctl_t                 ctl1_next;
  logic signed [W-1:0]  a1, b1, c1, d1;
  logic signed [PW-1:0] ac2, bd2, ad2, bc2, cc2, dd2;
  logic signed [W:0]    sre2, sim2;
  logic signed [SW-1:0] vre3, vim3;
  logic [PW-1:0]        den3;
  logic [SW-1:0]        mre, mim;

  always_comb begin
    ctl1_next.op = op_t'(kind);
    if (left_type[1] || right_type[1]) begin
      ctl1_next.rtype = TY_CPLX;
    end else if (left_type == TY_REAL || right_type == TY_REAL || kind == OP_DIV) begin
      ctl1_next.rtype = TY_REAL;
    end else begin
      ctl1_next.rtype = TY_INT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1 <= ctl1_next;
      a1 <= (left_type == TY_INT) ? (left_re & ~FMASK) : left_re;
      b1 <= left_type[1] ? left_im : '0;
      c1 <= (right_type == TY_INT) ? (right_re & ~FMASK) : right_re;
      d1 <= right_type[1] ? right_im : '0;

      ctl2 <= ctl1;
      ac2 <= a1 * c1;
      bd2 <= b1 * d1;
      ad2 <= a1 * d1;
      bc2 <= b1 * c1;
      cc2 <= c1 * c1;
      dd2 <= d1 * d1;
      if (ctl1.op == OP_SUB) begin
        sre2 <= (W+1)'(a1) - (W+1)'(c1);
        sim2 <= (W+1)'(b1) - (W+1)'(d1);
      end else begin
        sre2 <= (W+1)'(a1) + (W+1)'(c1);
        sim2 <= (W+1)'(b1) + (W+1)'(d1);
      end

      ctl3 <= ctl2;
      den3 <= $unsigned(cc2) + $unsigned(dd2);
      unique case (ctl2.op)
        OP_ADD, OP_SUB: begin
          vre3 <= SW'(sre2);
          vim3 <= SW'(sim2);
        end
        OP_MUL: begin
          vre3 <= SW'(ac2) - SW'(bd2);
          vim3 <= SW'(ad2) + SW'(bc2);
        end
        OP_DIV: begin
          vre3 <= SW'(ac2) + SW'(bd2);
          vim3 <= SW'(bc2) - SW'(ad2);
        end
        default: begin
          vre3 <= '0;
          vim3 <= '0;
        end
      endcase

      out_ctl.ctl <= ctl3;
      out_ctl.dz <= (den3 == '0);
      out_ctl.neg_re <= vre3[SW-1];
      out_ctl.neg_im <= vim3[SW-1];
      den <= den3;
      unique case (ctl3.op)
        OP_DIV: begin
          num_re <= NB'(mre) << F;
          num_im <= NB'(mim) << F;
        end
        OP_MUL: begin
          num_re <= NB'(mre >> F);
          num_im <= NB'(mim >> F);
        end
        default: begin
          num_re <= NB'(mre);
          num_im <= NB'(mim);
        end
      endcase
    end
  end

  assign mre = vre3[SW-1] ? SW'(-vre3) : SW'(vre3);
  assign mim = vim3[SW-1] ? SW'(-vim3) : SW'(vim3);

endmodule

// File: rtl/core/tca_divider.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes; other operations pass through.
module tca_divider #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  tca_pkg::dctl_t       in_ctl,
  input  logic [2*W+F:0]       in_re,
  input  logic [2*W+F:0]       in_im,
  input  logic [2*W-1:0]       in_den,
  output logic                 out_valid,
  output tca_pkg::dctl_t       out_ctl,
  output logic [2*W+F:0]       out_re,
  output logic [2*W+F:0]       out_im
);
  import tca_pkg::*;

  localparam int PW = 2 * W;
  localparam int NB = 2 * W + 1 + F;

  logic          vld [0:NB];
  dctl_t         dc  [0:NB];
  logic [NB-1:0] qre [0:NB];
  logic [NB-1:0] qim [0:NB];
  logic [PW-1:0] rre [0:NB];
  logic [PW-1:0] rim [0:NB];
  logic [PW-1:0] dv  [0:NB];

  assign vld[0] = in_valid;
  assign dc[0]  = in_ctl;
  assign qre[0] = in_re;
  assign qim[0] = in_im;
  assign rre[0] = '0;
  assign rim[0] = '0;
  assign dv[0]  = in_den;

  for (genvar k = 0; k < NB; k++) begin : g_step
    logic [PW+1:0] tre, tim;
    logic          is_div;

    assign is_div = (dc[k].ctl.op == OP_DIV);
    assign tre = {1'b0, rre[k], qre[k][NB-1]} - {2'b00, dv[k]};
    assign tim = {1'b0, rim[k], qim[k][NB-1]} - {2'b00, dv[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dc[k+1] <= dc[k];
        dv[k+1] <= dv[k];
        if (is_div) begin
          qre[k+1] <= {qre[k][NB-2:0], ~tre[PW+1]};
          qim[k+1] <= {qim[k][NB-2:0], ~tim[PW+1]};
          rre[k+1] <= tre[PW+1] ? {rre[k][PW-2:0], qre[k][NB-1]} : tre[PW-1:0];
          rim[k+1] <= tim[PW+1] ? {rim[k][PW-2:0], qim[k][NB-1]} : tim[PW-1:0];
        end else begin
          qre[k+1] <= qre[k];
          qim[k+1] <= qim[k];
          rre[k+1] <= '0;
          rim[k+1] <= '0;
        end
      end
    end
  end

  assign out_valid = vld[NB];
  assign out_ctl   = dc[NB];
  assign out_re    = qre[NB];
  assign out_im    = qim[NB];

endmodule

// File: rtl/core/tca_back.sv
// Sign restore, saturation, divide-by-zero handling and output register.
module tca_back #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  tca_pkg::dctl_t       in_ctl,
  input  logic [2*W+F:0]       in_re,
  input  logic [2*W+F:0]       in_im,
  output logic                 out_valid,
  output logic [1:0]           result_type,
  output logic signed [W-1:0]  result_re,
  output logic signed [W-1:0]  result_im,
  output logic [1:0]           status
);
  import tca_pkg::*;

  localparam int NB = 2 * W + 1 + F;
  localparam logic [NB-1:0] ONE    = NB'(1);
  localparam logic [NB-1:0] HI     = (ONE << (W - 1)) - ONE;
  localparam logic [NB-1:0] LOWF   = (ONE << F) - ONE;
  localparam logic [NB-1:0] HI_INT = HI & ~LOWF;
  localparam logic [NB-1:0] LO_MAG = ONE << (W - 1);

  logic [W:0]    lane_re, lane_im;
  logic [NB-1:0] lim, mag_im;

  function automatic logic [W:0] clamp_lane(input logic [NB-1:0] q, input logic neg,
                                            input logic [NB-1:0] top);
    logic [NB-1:0] nq;
    nq = NB'(0) - q;
    if (neg) begin
      clamp_lane = (q > LO_MAG) ? {1'b1, LO_MAG[W-1:0]} : {1'b0, nq[W-1:0]};
    end else begin
      clamp_lane = (q > top) ? {1'b1, top[W-1:0]} : {1'b0, q[W-1:0]};
    end
  endfunction

  assign lim     = (in_ctl.ctl.rtype == TY_INT) ? HI_INT : HI;
  assign mag_im  = (in_ctl.ctl.rtype == TY_CPLX) ? in_im : '0;
  assign lane_re = clamp_lane(in_re, in_ctl.neg_re, lim);
  assign lane_im = clamp_lane(mag_im, in_ctl.neg_im, lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_type <= in_ctl.ctl.rtype;
      if (in_ctl.ctl.op == OP_DIV && in_ctl.dz) begin
        result_re <= '0;
        result_im <= '0;
        status <= ST_DZ;
      end else begin
        result_re <= lane_re[W-1:0];
        result_im <= lane_im[W-1:0];
        status <= (lane_re[W] || lane_im[W]) ? ST_SAT : ST_OK;
      end
    end
  end

endmodule

// File: tb/typed_complex_arithmetic_top_tb.sv
// Testbench for typed_complex_arithmetic_top: directed and random operations checked against a predictor.
`timescale 1ns / 100ps

module typed_complex_arithmetic_top_tb;
  import tca_pkg::*;

  localparam int W = 32;
  localparam int FB = 16;
  localparam int LATENCY = 2 * W + FB + 6;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [1:0]          rtype;
    logic signed [W-1:0] re;
    logic signed [W-1:0] im;
    logic [1:0]          st;
  } result_t;

  logic clk;
  logic rst;
  int   cycle_count;
  int   mismatch_count;
  int   sent_count;
  int   checked_count;
  int   dz_count;
  int   sat_count;
  int   burst_left;
  result_t expected_results[$];

  tca_req_if #(.W(W)) req ();
  tca_rsp_if #(.W(W)) rsp ();

  typed_complex_arithmetic_top #(.WORD_BITS(W), .FRAC_BITS(FB)) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic wide_t scale_down(input wide_t v);
    if (v < 0) begin
      return -((-v) >>> FB);
    end
    return v >>> FB;
  endfunction

  function automatic result_t compute_result(input op_t k, input logic [1:0] lt,
                                             input logic signed [W-1:0] lre,
                                             input logic signed [W-1:0] lim,
                                             input logic [1:0] rt,
                                             input logic signed [W-1:0] rre,
                                             input logic signed [W-1:0] rim);
    wide_t a, b, c, d, re, im, den, hi, lo;
    logic sat;
    result_t r;
    a = wide_t'(lre);
    b = lt[1] ? wide_t'(lim) : 128'sd0;
    c = wide_t'(rre);
    d = rt[1] ? wide_t'(rim) : 128'sd0;
    if (lt == TY_INT) a[FB-1:0] = '0;
    if (rt == TY_INT) c[FB-1:0] = '0;
    if (lt[1] || rt[1]) r.rtype = TY_CPLX;
    else if (lt == TY_REAL || rt == TY_REAL || k == OP_DIV) r.rtype = TY_REAL;
    else r.rtype = TY_INT;
    r.st = ST_OK;
    case (k)
      OP_ADD: begin
        re = a + c;
        im = b + d;
      end
      OP_SUB: begin
        re = a - c;
        im = b - d;
      end
      OP_MUL: begin
        re = scale_down(a * c - b * d);
        im = scale_down(a * d + b * c);
      end
      default: begin
        den = c * c + d * d;
        if (den == 128'sd0) begin
          re = '0;
          im = '0;
          r.st = ST_DZ;
        end else begin
          re = ((a * c + b * d) <<< FB) / den;
          im = ((b * c - a * d) <<< FB) / den;
        end
      end
    endcase
    if (r.rtype != TY_CPLX) im = '0;
    if (r.st == ST_OK) begin
      hi = 128'sh7FFFFFFF;
      lo = -128'sh80000000;
      if (r.rtype == TY_INT) hi = 128'sh7FFF0000;
      sat = 1'b0;
      if (re > hi) begin re = hi; sat = 1'b1; end
      else if (re < lo) begin re = lo; sat = 1'b1; end
      if (im > hi) begin im = hi; sat = 1'b1; end
      else if (im < lo) begin im = lo; sat = 1'b1; end
      if (sat) r.st = ST_SAT;
    end
    r.re = re[W-1:0];
    r.im = im[W-1:0];
    return r;
  endfunction

  task automatic send_item(input op_t k, input logic [1:0] lt, input logic [W-1:0] lre,
                           input logic [W-1:0] lim, input logic [1:0] rt,
                           input logic [W-1:0] rre, input logic [W-1:0] rim);
    req.valid      <= 1'b1;
    req.kind       <= k;
    req.left_type  <= lt;
    req.left_re    <= lre;
    req.left_im    <= lim;
    req.right_type <= rt;
    req.right_re   <= rre;
    req.right_im   <= rim;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_results.push_back(compute_result(k, lt, lre, lim, rt, rre, rim));
    sent_count++;
  endtask

  // Between bursts, hold valid low for a random gap in two of three cases.
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = ($urandom % 4 == 0) ? 60 : $urandom_range(1, 12);
      if ($urandom % 3 != 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  function automatic logic [W-1:0] pick_value();
    case ($urandom % 6)
      0: return $urandom;
      1: return W'($signed($urandom_range(0, 8)) - 4) << FB;
      2: return W'($signed($urandom_range(0, 2000)) - 1000) << 8 | W'($urandom % 256);
      3: return $urandom % 2 ? 32'h7FFFFFFF - $urandom_range(0, 3) :
                               32'h80000000 + $urandom_range(0, 3);
      4: return 0;
      default: return $signed($urandom) >>> $urandom_range(0, 24);
    endcase
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) begin
      pace_sender();
      send_item(op_t'($urandom % 4), 2'($urandom % 4), pick_value(), pick_value(),
                2'($urandom % 4), pick_value(), pick_value());
    end
  endtask

  task automatic test_directed();
    send_item(OP_ADD, TY_INT, 32'h7FFF0000, 32'h12345678, TY_INT, 32'h00010000, 0);
    send_item(OP_ADD, TY_REAL, 32'h7FFFFFFF, 32'hFFFFFFFF, TY_REAL, 32'h7FFFFFFF, 0);
    send_item(OP_SUB, TY_REAL, 32'h80000000, 0, TY_REAL, 32'h7FFFFFFF, 0);
    send_item(OP_SUB, TY_INT, 32'hFFFF8000, 0, TY_INT, 32'h00018000, 0);
    send_item(OP_MUL, TY_REAL, 32'h80000000, 0, TY_REAL, 32'h80000000, 0);
    send_item(OP_MUL, TY_CPLX, 32'h00020000, 32'h00030000, TY_CPLX, 32'h00040000,
              32'hFFFB0000);
    send_item(OP_MUL, TY_INT, 32'h00030000, 0, TY_INT, 32'hFFFE0000, 0);
    send_item(OP_MUL, TY_REAL, 32'hFFFFFFFF, 0, TY_REAL, 32'h00008000, 0);
    send_item(OP_DIV, TY_INT, 32'h00070000, 0, TY_INT, 32'h00020000, 0);
    send_item(OP_DIV, TY_REAL, 32'hFFF90000, 0, TY_REAL, 32'h00020000, 0);
    send_item(OP_DIV, TY_CPLX, 32'h00010000, 32'h00020000, TY_CPLX, 32'h00030000,
              32'h00040000);
    send_item(OP_DIV, TY_INT, 32'h00050000, 0, TY_INT, 32'h0000FFFF, 0);
    send_item(OP_DIV, TY_REAL, 32'h00050000, 0, TY_REAL, 0, 32'h00010000);
    send_item(OP_DIV, TY_CPLX, 32'h00050000, 32'h1, TY_CPLX, 0, 0);
    send_item(OP_DIV, TY_REAL, 32'h80000000, 0, TY_REAL, 32'hFFFFFFFF, 0);
    send_item(OP_DIV, TY_REAL, 32'h7FFFFFFF, 0, TY_REAL, 32'h00000001, 0);
    send_item(OP_ADD, 2'd3, 32'h00010000, 32'h7FFFFFFF, TY_INT, 32'h0001FFFF, 32'hFFFFFFFF);
    send_item(OP_SUB, TY_REAL, 32'h00010000, 32'h7FFFFFFF, 2'd3, 32'h1, 32'h80000000);
    send_item(OP_MUL, 2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_item(OP_DIV, 2'd3, 32'h7FFFFFFF, 32'h80000000, TY_INT, 32'hFFFF0000, 32'h55555555);
    send_item(OP_ADD, TY_INT, 32'h80000000, 0, TY_INT, 32'hFFFFFFFF, 0);
  endtask

  task automatic test_random_mixed();
    send_random(1300);
  endtask

  task automatic test_divide_by_zero();
    for (int i = 0; i < 150; i++) begin
      pace_sender();
      send_item(OP_DIV, 2'($urandom % 4), pick_value(), pick_value(), 2'($urandom % 4),
                $urandom % 2 ? 0 : $urandom % 65536, $urandom % 2 ? 0 : $urandom);
    end
  endtask

  task automatic test_small_values();
    for (int i = 0; i < 180; i++) begin
      pace_sender();
      send_item(op_t'($urandom % 4), 2'($urandom % 3), $signed($urandom) >>> 12,
                $signed($urandom) >>> 12, 2'($urandom % 3), $signed($urandom) >>> 12,
                $signed($urandom) >>> 12);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case ((cycle_count / 700) % 3)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= ($urandom % 4 != 0);
      default: rsp.ready <= (cycle_count % 16 >= 5);
    endcase
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected response at cycle %0d", cycle_count);
      end else begin
        exp_r = expected_results.pop_front();
        checked_count++;
        if (exp_r.st == ST_DZ) dz_count++;
        if (exp_r.st == ST_SAT) sat_count++;
        if (rsp.result_type !== exp_r.rtype || rsp.result_re !== exp_r.re ||
            rsp.result_im !== exp_r.im || rsp.status !== exp_r.st) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch on result %0d: expected type %0d re %h im %h status %0d,",
                     checked_count, exp_r.rtype, exp_r.re, exp_r.im, exp_r.st);
            $display("  got type %0d re %h im %h status %0d", rsp.result_type,
                     rsp.result_re, rsp.result_im, rsp.status);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cycle_count = 0;
    mismatch_count = 0;
    sent_count = 0;
    checked_count = 0;
    dz_count = 0;
    sat_count = 0;
    burst_left = 0;
    rsp.ready = 1'b0;
    req.valid = 1'b0;
    req.kind = OP_ADD;
    req.left_type = TY_INT;
    req.left_re = '0;
    req.left_im = '0;
    req.right_type = TY_INT;
    req.right_re = '0;
    req.right_im = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mixed();
    test_divide_by_zero();
    test_small_values();
    req.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d operations, checked %0d results", sent_count, checked_count);
    $display("Divide-by-zero results %0d, saturated results %0d, mismatches %0d",
             dz_count, sat_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/tca_pkg.sv
rtl/core/tca_if.sv
rtl/core/tca_front.sv
rtl/core/tca_divider.sv
rtl/core/tca_back.sv
rtl/core/typed_complex_arithmetic_top.sv
tb/typed_complex_arithmetic_top_tb.sv
